### src/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg: shared types and constants of the bounded ordered list engine
// Sizes, request and status codes, and the per-cell command.
// ----------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int POS_W   = 8;
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int DATA_W  = 32;
    localparam int OPC_W   = 2;
    localparam int STAT_W  = 3;
    localparam int ECNT_W  = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [IDX_W-1:0]         idx_t;

    typedef enum logic [OPC_W-1:0] {
        OP_INS_FRONT  = 2'd0,
        OP_INS_END    = 2'd1,
        OP_REM_LAST   = 2'd2,
        OP_REM_BEFORE = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_NOPREV = 3'd3,
        ST_BEYOND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_FRONT  = 2'd1,
        CELL_END    = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        idx_t     sel;
    } cell_cmd_t;

endpackage

`default_nettype wire

### src/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: ordered list of signed entries held in cells
// Insert at front or end, remove last, or remove before a position; every
// request gives one result with status, removed value and new count.
// ----------------------------------------------------------------------------
// Result: the result of each accepted request is registered in the output register.
// Throughput: one request per cycle while m_tready stays high; every cell
//   shifts or loads in parallel at the accepting edge. A held result with
//   m_tready low stalls the input until it is taken.
// Reset: aresetn (synchronous, active low) empties the list and the output
//   register; the cell contents are left as they are.
`default_nettype none

module bounded_ordered_list_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // opcode[1:0], value[33:2], position[41:34], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata   // status[2:0], removed_value[34:3], entry_count[39:35]
);

    bole_pkg::opcode_t    opcode;
    bole_pkg::data_t      value;
    logic [bole_pkg::POS_W-1:0] position;

    logic                 go;
    bole_pkg::cnt_t       count_reg;
    bole_pkg::cnt_t       count_next;
    bole_pkg::status_t    status;
    bole_pkg::cell_cmd_t  cmd;

    bole_pkg::data_t      cell_data [bole_pkg::DEPTH];
    bole_pkg::data_t      cell_rd   [bole_pkg::DEPTH];
    bole_pkg::data_t      removed;

    logic                 out_valid_reg;
    bole_pkg::status_t    out_status_reg;
    bole_pkg::data_t      out_removed_reg;
    logic [bole_pkg::ECNT_W-1:0] out_count_reg;
    logic [bole_pkg::CNT_W+bole_pkg::ECNT_W-1:0] count_wide;

    assign opcode   = bole_pkg::opcode_t'(s_tdata[1:0]);
    assign value    = s_tdata[33:2];
    assign position = s_tdata[41:34];

    assign s_tready = !out_valid_reg || m_tready;
    assign go       = s_tvalid && s_tready;

    bole_ctrl u_ctrl (
        .go         (go),
        .opcode     (opcode),
        .position   (position),
        .count      (count_reg),
        .status     (status),
        .count_next (count_next),
        .cmd        (cmd)
    );

    for (genvar i = 0; i < bole_pkg::DEPTH; i++) begin : g_cell
        bole_pkg::data_t left_d;
        bole_pkg::data_t right_d;
        if (i == 0) begin : g_first
            assign left_d = value;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == bole_pkg::DEPTH - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        bole_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .my_idx     (bole_pkg::IDX_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .ins_value  (value),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // only the selected cell drives a nonzero read
    always_comb begin
        removed = '0;
        for (int i = 0; i < bole_pkg::DEPTH; i++) begin
            removed = removed | cell_rd[i];
        end
    end

    assign count_wide = {{bole_pkg::ECNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (go) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            out_status_reg  <= status;
            out_removed_reg <= removed;
            out_count_reg   <= count_wide[bole_pkg::ECNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_removed_reg, out_status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bole_pkg::CNT_W'(bole_pkg::DEPTH))
        else $error("entry count exceeds depth");

    a_fail_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != bole_pkg::ST_OK) |-> out_removed_reg == '0)
        else $error("failed request reports a removed value");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && status == bole_pkg::ST_OK &&
         (opcode == bole_pkg::OP_INS_FRONT || opcode == bole_pkg::OP_INS_END))
        |=> count_reg == $past(count_reg) + bole_pkg::CNT_W'(1))
        else $error("insert did not grow the list");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !go |=> $stable(count_reg))
        else $error("count changed without a transaction");

endmodule

`default_nettype wire

### src/bole_cell.sv
// ----------------------------------------------------------------------------
// bole_cell: one list slot
// Holds one entry; takes its left or right neighbor, loads the new value,
// or holds, as the broadcast command and its own index decide.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_cell (
    input  wire logic               aclk,
    input  wire bole_pkg::cell_cmd_t cmd,
    input  wire bole_pkg::idx_t      my_idx,
    input  wire bole_pkg::data_t     left_data,
    input  wire bole_pkg::data_t     right_data,
    input  wire bole_pkg::data_t     ins_value,
    output bole_pkg::data_t          data,
    output bole_pkg::data_t          rd_data
);

    bole_pkg::data_t data_reg;
    bole_pkg::data_t data_next;

    always_comb begin
        data_next = data_reg;
        unique case (cmd.op)
            bole_pkg::CELL_HOLD:   data_next = data_reg;
            bole_pkg::CELL_FRONT:  data_next = left_data;
            bole_pkg::CELL_END: begin
                if (my_idx == cmd.sel) begin
                    data_next = ins_value;
                end
            end
            bole_pkg::CELL_REMOVE: begin
                // close the gap: everything from the removed slot up moves down
                if (my_idx >= cmd.sel) begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (cmd.op == bole_pkg::CELL_REMOVE && my_idx == cmd.sel) ?
                     data_reg : '0;

endmodule

`default_nettype wire

### src/bole_ctrl.sv
// ----------------------------------------------------------------------------
// bole_ctrl: request decoder
// Checks a request against the current count, returns its status and the
// new count, and builds the command broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_ctrl (
    input  wire logic                go,
    input  wire bole_pkg::opcode_t    opcode,
    input  wire logic [bole_pkg::POS_W-1:0] position,
    input  wire bole_pkg::cnt_t       count,
    output bole_pkg::status_t         status,
    output bole_pkg::cnt_t            count_next,
    output bole_pkg::cell_cmd_t       cmd
);

    logic                       full;
    logic                       empty;
    logic [bole_pkg::CMP_W-1:0] pos_ext;
    logic [bole_pkg::CMP_W-1:0] cnt_plus1;
    logic [bole_pkg::CMP_W-1:0] pos_less2;
    bole_pkg::cnt_t             cnt_less1;

    assign full      = (count == bole_pkg::CNT_W'(bole_pkg::DEPTH));
    assign empty     = (count == '0);
    assign pos_ext   = bole_pkg::CMP_W'(position);
    assign cnt_plus1 = bole_pkg::CMP_W'(count) + bole_pkg::CMP_W'(1);
    assign pos_less2 = pos_ext - bole_pkg::CMP_W'(2);
    assign cnt_less1 = count - bole_pkg::CNT_W'(1);

    always_comb begin
        status     = bole_pkg::ST_OK;
        count_next = count;
        cmd.op     = bole_pkg::CELL_HOLD;
        cmd.sel    = '0;
        unique case (opcode)
            bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_END: begin
                if (full) begin
                    status = bole_pkg::ST_FULL;
                end else begin
                    count_next = count + bole_pkg::CNT_W'(1);
                    cmd.op     = (opcode == bole_pkg::OP_INS_FRONT) ?
                                 bole_pkg::CELL_FRONT : bole_pkg::CELL_END;
                    cmd.sel    = count[bole_pkg::IDX_W-1:0];
                end
            end
            bole_pkg::OP_REM_LAST: begin
                if (empty) begin
                    status = bole_pkg::ST_EMPTY;
                end else begin
                    count_next = cnt_less1;
                    cmd.op     = bole_pkg::CELL_REMOVE;
                    cmd.sel    = cnt_less1[bole_pkg::IDX_W-1:0];
                end
            end
            bole_pkg::OP_REM_BEFORE: begin
                priority if (pos_ext <= bole_pkg::CMP_W'(1)) begin
                    status = bole_pkg::ST_NOPREV;
                end else if (empty) begin
                    status = bole_pkg::ST_EMPTY;
                end else if (pos_ext > cnt_plus1) begin
                    status = bole_pkg::ST_BEYOND;
                end else begin
                    count_next = cnt_less1;
                    cmd.op     = bole_pkg::CELL_REMOVE;
                    cmd.sel    = pos_less2[bole_pkg::IDX_W-1:0];
                end
            end
            default: status = bole_pkg::ST_OK;
        endcase
        // no transaction this cycle: leave the cells alone
        if (!go) begin
            cmd.op = bole_pkg::CELL_HOLD;
        end
    end

endmodule

`default_nettype wire
